/* sv/aoct_pkg.sv */
// Package for the address occurrence count table.
// Holds shared constants and the status codes; depends on nothing.
`timescale 1ns / 1ps
package aoct_pkg;
  localparam int unsigned BucketBitsDefault = 10;
  localparam int unsigned WaysDefault = 4;
  localparam logic [31:0] HashMultReset = 32'd1640531527;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    StCounted  = 2'd0,
    StInserted = 2'd1,
    StDropped  = 2'd2,
    StRead     = 2'd3
  } status_e;
endpackage

/* sv/aoct_hash.sv */
// Multiplicative hash of an address into a bucket number, one register stage.
// Depends on aoct_pkg.
`timescale 1ns / 1ps
module aoct_hash #(
  parameter int unsigned BUCKET_BITS = aoct_pkg::BucketBitsDefault
) (
  input  logic                   clk_i,
  input  logic [31:0]            address_i,
  input  logic [31:0]            mult_i,
  output logic [BUCKET_BITS-1:0] bucket_o
);
  import aoct_pkg::*;
  logic [31:0] product;
  assign product = address_i * mult_i;
  always_ff @(posedge clk_i) begin
    bucket_o <= product[31 -: BUCKET_BITS];
  end
endmodule

/* sv/aoct_way_mem.sv */
// One way of the table: a memory of valid flag, address and count per bucket.
// Synchronous, registered read; depends on aoct_pkg.
`timescale 1ns / 1ps
module aoct_way_mem #(
  parameter int unsigned BUCKET_BITS = aoct_pkg::BucketBitsDefault
) (
  input  logic                   clk_i,
  input  logic [BUCKET_BITS-1:0] rd_addr_i,
  output logic                   rd_valid_o,
  output logic [31:0]            rd_address_o,
  output logic [31:0]            rd_count_o,
  input  logic                   wr_en_i,
  input  logic [BUCKET_BITS-1:0] wr_addr_i,
  input  logic                   wr_valid_i,
  input  logic [31:0]            wr_address_i,
  input  logic [31:0]            wr_count_i
);
  import aoct_pkg::*;
  localparam int unsigned Depth = 1 << BUCKET_BITS;
  logic [64:0] mem [Depth];
  logic [64:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_valid_i, wr_address_i, wr_count_i};
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_valid_o   = rd_q[64];
  assign rd_address_o = rd_q[63:32];
  assign rd_count_o   = rd_q[31:0];
endmodule

/* sv/address_occurrence_count_table.sv */
// Top level of the address occurrence count table.
// Depends on aoct_pkg, aoct_hash and aoct_way_mem.
`timescale 1ns / 1ps
// Usage: the input channel carries one transaction per request (action,
// address, entry_index) under valid/stall; the output channel returns one
// result transaction per request. A count request hashes the address with the
// configured multiplier into a bucket, reads all ways of that bucket in
// parallel (one memory per way), and increments a match with saturation,
// inserts into the lowest free way, or reports the bucket as full. A read
// request returns one entry by index; indexes beyond the table read as free.
// After the accepting edge a transaction passes through the states SHash
// (hash register), SAddr (issuing the memory read) and SRead (deciding and
// writing back), and then presents its result in SOut. Only one transaction
// is in flight, so no new request is taken until the last result is
// delivered; the input stall interlocks accesses to the same entry and no
// forwarding is needed.
// The result register holds a finished result while out_stall_i is high; no
// new transaction is taken until it is delivered. After reset a clearing pass
// over all 2^BUCKET_BITS buckets (1024 by default) marks every entry free while
// in_stall_o is high, and the hash multiplier returns to its reset value.
// Configuration writes must occur only while the block is idle.
module address_occurrence_count_table #(
  parameter int unsigned BUCKET_BITS = aoct_pkg::BucketBitsDefault,
  parameter int unsigned WAYS = aoct_pkg::WaysDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] address_i,
  input  logic [11:0] entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_address_o,
  output logic [31:0] entry_count_o
);
  import aoct_pkg::*;
  localparam int unsigned WayBits = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Slots = (1 << BUCKET_BITS) * WAYS;
  localparam int unsigned RecipShift = 17;
  localparam int unsigned WaysRecip = ((1 << RecipShift) + WAYS - 1) / WAYS;

  typedef enum logic [5:0] {
    SClear = 6'b000001,
    SIdle  = 6'b000010,
    SHash  = 6'b000100,
    SAddr  = 6'b001000,
    SRead  = 6'b010000,
    SOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] mult_q;
  logic action_q;
  logic [31:0] addr_q;
  logic [11:0] idx_q;
  logic [BUCKET_BITS-1:0] hash_bucket, bucket_q;
  logic [BUCKET_BITS-1:0] rd_bucket, bucket_d;
  logic [BUCKET_BITS-1:0] clr_q, wr_bucket;
  logic wr_valid;
  logic [WayBits-1:0] rway_q;
  logic rd_oob_q;

  logic [WAYS-1:0] rv;
  logic [31:0] ra [WAYS];
  logic [31:0] rc [WAYS];
  logic [WAYS-1:0] wen;

  logic [1:0] st_d;
  logic ev_d;
  logic [31:0] ea_d, ec_d;
  logic [31:0] wr_cnt;

  // Read index split: the bucket is the index over WAYS, found by a reciprocal
  // multiplication that is exact for every 12-bit index; the way is the rest.
  logic [29:0] rd_prod;
  logic [11:0] rd_bucket_full;
  logic [WayBits-1:0] rd_way;
  assign rd_prod = 30'(idx_q) * 30'(WaysRecip);
  assign rd_bucket_full = 12'(rd_prod >> RecipShift);
  assign rd_way = WayBits'(idx_q - rd_bucket_full * 12'(WAYS));
  assign rd_bucket = BUCKET_BITS'(rd_bucket_full);

  // Count uses the hash; read uses the index split.
  assign bucket_d = action_q ? rd_bucket : hash_bucket;

  // The clearing pass writes free entries over all ways, one bucket a cycle.
  assign wr_bucket = (state_q == SClear) ? clr_q : bucket_q;
  assign wr_valid  = (state_q != SClear);

  aoct_hash #(.BUCKET_BITS(BUCKET_BITS)) u_hash (
    .clk_i(clk_i), .address_i(addr_q), .mult_i(mult_q), .bucket_o(hash_bucket)
  );

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    aoct_way_mem #(.BUCKET_BITS(BUCKET_BITS)) u_mem (
      .clk_i(clk_i),
      .rd_addr_i(bucket_d),
      .rd_valid_o(rv[w]), .rd_address_o(ra[w]), .rd_count_o(rc[w]),
      .wr_en_i(wen[w]), .wr_addr_i(wr_bucket), .wr_valid_i(wr_valid),
      .wr_address_i(addr_q), .wr_count_i(wr_cnt)
    );
  end

  // Decide the outcome from the ways that were read.
  always_comb begin
    logic hit, have_free;
    logic [WayBits-1:0] hw, fw;
    hit = 1'b0;
    have_free = 1'b0;
    hw = '0;
    fw = '0;
    wen = '0;
    wr_cnt = 32'd1;
    st_d = StRead;
    ev_d = 1'b0;
    ea_d = '0;
    ec_d = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rv[w] && ra[w] == addr_q) begin
        hit = 1'b1;
        hw = WayBits'(w);
      end
      if (!rv[w]) begin
        have_free = 1'b1;
        fw = WayBits'(w);
      end
    end
    if (action_q) begin
      st_d = StRead;
      if (!rd_oob_q && rv[rway_q]) begin
        ev_d = 1'b1;
        ea_d = ra[rway_q];
        ec_d = rc[rway_q];
      end
    end else if (hit) begin
      wr_cnt = (rc[hw] == CountMax) ? CountMax : rc[hw] + 32'd1;
      st_d = StCounted;
      ev_d = 1'b1;
      ea_d = addr_q;
      ec_d = wr_cnt;
      if (state_q == SRead) wen[hw] = 1'b1;
    end else if (have_free) begin
      st_d = StInserted;
      ev_d = 1'b1;
      ea_d = addr_q;
      ec_d = 32'd1;
      if (state_q == SRead) wen[fw] = 1'b1;
    end else begin
      st_d = StDropped;
      ea_d = addr_q;
    end
    if (state_q == SClear) wen = '1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: if (&clr_q) state_d = SIdle;
      SIdle: if (in_valid_i) state_d = SHash;
      SHash: state_d = SAddr;
      SAddr: state_d = SRead;
      SRead: state_d = SOut;
      SOut:  if (!out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      mult_q  <= HashMultReset;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mult_q <= cfg_wdata_i;
      if (state_q == SClear) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      action_q <= action_i;
      addr_q   <= address_i;
      idx_q    <= entry_index_i;
    end
    if (state_q == SHash) begin
      rway_q   <= rd_way;
      rd_oob_q <= (32'(idx_q) >= 32'(Slots));
    end
    if (state_q == SAddr) begin
      bucket_q <= bucket_d;
    end
    if (state_q == SRead) begin
      status_o        <= st_d;
      entry_valid_o   <= ev_d;
      entry_address_o <= ea_d;
      entry_count_o   <= ec_d;
    end
  end
endmodule
